// ===== hdl/sidu_pkg.sv =====
// ----------------------------------------------------------------------------
// sidu_pkg
// Types and constants shared by the signed integer divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sidu_pkg;

    localparam int QUOT_BITS  = 64;
    localparam int STEP_BITS  = 2;
    localparam int DIV_STAGES = QUOT_BITS / STEP_BITS;

    typedef enum logic [1:0] {
        SIZE_8  = 2'd0,
        SIZE_16 = 2'd1,
        SIZE_32 = 2'd2,
        SIZE_64 = 2'd3
    } size_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // num holds the dividend bits still to come at the top and the quotient
    // bits found so far at the bottom.
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] num;
        logic [63:0] dmag;
        logic        qneg;
        logic        nneg;
        size_t       size;
        status_t     status;
    } sidu_word_t;

endpackage

`default_nettype wire

// ===== hdl/sidu_req_if.sv =====
// ----------------------------------------------------------------------------
// sidu_req_if
// Request channel: operand size, dividend halves and divisor.
// ----------------------------------------------------------------------------
`default_nettype none

interface sidu_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op_size;
    logic [63:0] dividend_high;
    logic [63:0] dividend_low;
    logic [63:0] divisor_value;

    modport source (output valid, output op_size, output dividend_high,
                    output dividend_low, output divisor_value, input ready);
    modport sink   (input valid, input op_size, input dividend_high,
                    input dividend_low, input divisor_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/sidu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sidu_rsp_if
// Response channel: quotient, remainder and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface sidu_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] quotient;
    logic [63:0] remainder;
    logic [1:0]  status;

    modport source (output valid, output quotient, output remainder,
                    output status, input ready);
    modport sink   (input valid, input quotient, input remainder,
                    input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/signed_integer_divide_unit.sv =====
// ----------------------------------------------------------------------------
// signed_integer_divide_unit
// Pipelined signed divide (IDIV) for 8, 16, 32 and 64 bit operand sizes.
//
// A request beat on req carries the operand size, the dividend halves and
// the divisor; a response beat on rsp carries the truncated quotient, the
// remainder (sign of the dividend) and a status: ok, divide by zero or
// quotient overflow. On any error both result fields are zero.
// The path from request beat to response valid runs through three front
// stages (sign extension, magnitudes, high-part overflow check), 32 divider
// stages of two restoring steps each, and the output register.
// Throughput is one beat per cycle while the receiver does not stall.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req.ready drops; nothing is lost or repeated. Reset clears all valid
// bits; the block accepts a beat in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_divide_unit
    import sidu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sidu_req_if.sink   req,
    sidu_rsp_if.source rsp
);

    logic adv;

    logic         f1_vld_reg;
    logic [127:0] f1_num_reg;
    logic [63:0]  f1_div_reg;
    logic         f1_zero_reg;
    size_t        f1_size_reg;
    logic [127:0] f1_num_next;
    logic [63:0]  f1_div_next;
    logic         f1_zero_next;
    size_t        f1_size_next;

    logic         f2_vld_reg;
    logic [127:0] f2_nmag_reg;
    logic [63:0]  f2_dmag_reg;
    logic         f2_zero_reg;
    logic         f2_nneg_reg;
    logic         f2_qneg_reg;
    size_t        f2_size_reg;

    logic [DIV_STAGES:0] chain_vld;
    sidu_word_t          chain_word [0:DIV_STAGES];
    logic                f3_vld_reg;
    sidu_word_t          f3_word_reg;
    sidu_word_t          f3_word_next;

    logic        rsp_vld_reg;
    logic [63:0] rsp_quot_reg;
    logic [63:0] rsp_rem_reg;
    status_t     rsp_status_reg;
    logic [63:0] rsp_quot_next;
    logic [63:0] rsp_rem_next;
    status_t     rsp_status_next;

    assign adv       = !rsp_vld_reg || rsp.ready;
    assign req.ready = adv;

    // Sign-extend dividend to 128 bits and divisor to 64 bits.
    always_comb
    begin
        f1_size_next = size_t'(req.op_size);
        case (f1_size_next)
            SIZE_8:
            begin
                f1_num_next  = {{112{req.dividend_low[15]}}, req.dividend_low[15:0]};
                f1_div_next  = {{56{req.divisor_value[7]}}, req.divisor_value[7:0]};
                f1_zero_next = (req.divisor_value[7:0] == 8'd0);
            end
            SIZE_16:
            begin
                f1_num_next  = {{96{req.dividend_high[15]}}, req.dividend_high[15:0],
                                req.dividend_low[15:0]};
                f1_div_next  = {{48{req.divisor_value[15]}}, req.divisor_value[15:0]};
                f1_zero_next = (req.divisor_value[15:0] == 16'd0);
            end
            SIZE_32:
            begin
                f1_num_next  = {{64{req.dividend_high[31]}}, req.dividend_high[31:0],
                                req.dividend_low[31:0]};
                f1_div_next  = {{32{req.divisor_value[31]}}, req.divisor_value[31:0]};
                f1_zero_next = (req.divisor_value[31:0] == 32'd0);
            end
            default:
            begin
                f1_num_next  = {req.dividend_high, req.dividend_low};
                f1_div_next  = req.divisor_value;
                f1_zero_next = (req.divisor_value == 64'd0);
            end
        endcase
    end

    // Initial remainder is the high magnitude; it must stay below the divisor.
    always_comb
    begin
        f3_word_next.rem   = f2_nmag_reg[127:64];
        f3_word_next.num   = f2_nmag_reg[63:0];
        f3_word_next.dmag  = f2_dmag_reg;
        f3_word_next.qneg  = f2_qneg_reg;
        f3_word_next.nneg  = f2_nneg_reg;
        f3_word_next.size  = f2_size_reg;
        if (f2_zero_reg)
            f3_word_next.status = STATUS_DIV_ZERO;
        else if (f2_nmag_reg[127:64] >= f2_dmag_reg)
            f3_word_next.status = STATUS_OVERFLOW;
        else
            f3_word_next.status = STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            f3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_vld_reg <= req.valid;
            f2_vld_reg <= f1_vld_reg;
            f3_vld_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_num_reg  <= f1_num_next;
            f1_div_reg  <= f1_div_next;
            f1_zero_reg <= f1_zero_next;
            f1_size_reg <= f1_size_next;

            f2_nmag_reg <= f1_num_reg[127] ? (~f1_num_reg + 128'd1) : f1_num_reg;
            f2_dmag_reg <= f1_div_reg[63] ? (~f1_div_reg + 64'd1) : f1_div_reg;
            f2_zero_reg <= f1_zero_reg;
            f2_nneg_reg <= f1_num_reg[127];
            f2_qneg_reg <= f1_num_reg[127] ^ f1_div_reg[63];
            f2_size_reg <= f1_size_reg;

            f3_word_reg <= f3_word_next;
        end
    end

    assign chain_vld[0]  = f3_vld_reg;
    assign chain_word[0] = f3_word_reg;

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        sidu_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .vld_in   (chain_vld[s]),
            .word_in  (chain_word[s]),
            .vld_out  (chain_vld[s+1]),
            .word_out (chain_word[s+1])
        );
    end

    // Range check, sign fix-up and masking to the operand size.
    always_comb
    begin
        sidu_word_t  last;
        logic [63:0] lim;
        logic [63:0] mask;
        logic [63:0] qs;
        logic [63:0] rs;
        last = chain_word[DIV_STAGES];
        case (last.size)
            SIZE_8:  begin lim = 64'h80;               mask = 64'hFF;        end
            SIZE_16: begin lim = 64'h8000;             mask = 64'hFFFF;      end
            SIZE_32: begin lim = 64'h8000_0000;        mask = 64'hFFFF_FFFF; end
            default: begin lim = 64'h8000_0000_0000_0000; mask = '1;         end
        endcase
        qs = last.qneg ? (~last.num + 64'd1) : last.num;
        rs = last.nneg ? (~last.rem + 64'd1) : last.rem;
        rsp_status_next = last.status;
        if (last.status == STATUS_OK &&
            (last.num > lim || (last.num == lim && !last.qneg)))
            rsp_status_next = STATUS_OVERFLOW;
        if (rsp_status_next == STATUS_OK)
        begin
            rsp_quot_next = qs & mask;
            rsp_rem_next  = rs & mask;
        end
        else
        begin
            rsp_quot_next = '0;
            rsp_rem_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_vld_reg <= 1'b0;
        else if (adv)
            rsp_vld_reg <= chain_vld[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_quot_reg   <= rsp_quot_next;
            rsp_rem_reg    <= rsp_rem_next;
            rsp_status_reg <= rsp_status_next;
        end
    end

    assign rsp.valid     = rsp_vld_reg;
    assign rsp.quotient  = rsp_quot_reg;
    assign rsp.remainder = rsp_rem_reg;
    assign rsp.status    = rsp_status_reg;

    a_err_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_vld_reg && rsp_status_reg != STATUS_OK
            |-> rsp_quot_reg == 64'd0 && rsp_rem_reg == 64'd0)
        else $error("error response with nonzero result");

    a_stall_holds_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(chain_vld))
        else $error("divider chain moved during stall");

    a_init_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        f3_vld_reg && f3_word_reg.status == STATUS_OK
            |-> f3_word_reg.rem < f3_word_reg.dmag)
        else $error("initial remainder not below divisor");

    a_final_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        chain_vld[DIV_STAGES] && chain_word[DIV_STAGES].status == STATUS_OK
            |-> chain_word[DIV_STAGES].rem < chain_word[DIV_STAGES].dmag)
        else $error("final remainder not below divisor");

endmodule

`default_nettype wire

// ===== hdl/sidu_div_step.sv =====
// ----------------------------------------------------------------------------
// sidu_div_step
// One pipeline stage of the restoring divider: STEP_BITS quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sidu_div_step
    import sidu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       vld_in,
    input  wire sidu_word_t word_in,
    output logic            vld_out,
    output sidu_word_t      word_out
);

    logic       vld_reg;
    sidu_word_t word_reg;
    sidu_word_t word_next;

    always_comb
    begin
        logic [63:0] cand;
        word_next = word_in;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            cand = {word_next.rem[62:0], word_next.num[63]};
            word_next.num = {word_next.num[62:0], 1'b0};
            if (cand >= word_next.dmag)
            begin
                word_next.rem    = cand - word_next.dmag;
                word_next.num[0] = 1'b1;
            end
            else
            begin
                word_next.rem = cand;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            word_reg <= word_next;
    end

    assign vld_out  = vld_reg;
    assign word_out = word_reg;

endmodule

`default_nettype wire

// ===== tb/sv/sidu_checker.sv =====
// ----------------------------------------------------------------------------
// sidu_checker
// Watches the request and response channels of the divide unit, computes
// the expected quotient, remainder and status of every request beat with a
// 128/64 restoring division, and compares each response beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module sidu_checker
    import sidu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sidu_req_if.sink  req_mon,
    sidu_rsp_if.sink  rsp_mon,
    output int        error_count,
    output int        pending_count
);

    typedef struct packed {
        logic [63:0] quotient;
        logic [63:0] remainder;
        status_t     status;
    } idiv_result_t;

    idiv_result_t expected_results[$];

    function automatic idiv_result_t compute_idiv(logic [1:0] size_code,
        logic [63:0] dhi, logic [63:0] dlo, logic [63:0] dvr);
        idiv_result_t res;
        int           width;
        logic [63:0]  mask;
        logic [63:0]  dv;
        logic [63:0]  dmag;
        logic [127:0] num;
        logic [127:0] quo;
        logic [64:0]  part;
        logic         nneg;
        logic         dneg;
        logic         qneg;
        logic [63:0]  lim;
        width = 8 << size_code;
        mask  = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
        dv    = dvr & mask;
        res   = '{quotient: '0, remainder: '0, status: STATUS_OK};
        if (dv == '0)
        begin
            res.status = STATUS_DIV_ZERO;
            return res;
        end
        case (size_code)
            SIZE_8:  num = {{112{dlo[15]}}, dlo[15:0]};
            SIZE_16: num = {{96{dhi[15]}}, dhi[15:0], dlo[15:0]};
            SIZE_32: num = {{64{dhi[31]}}, dhi[31:0], dlo[31:0]};
            default: num = {dhi, dlo};
        endcase
        nneg = num[127];
        dneg = dv[width-1];
        if (dneg)
            dv = dv | ~mask;
        dmag = dneg ? (~dv + 64'd1) : dv;
        if (nneg)
            num = ~num + 128'd1;
        part = '0;
        quo  = '0;
        for (int i = 127; i >= 0; i--)
        begin
            part = {part[63:0], num[i]};
            if (part >= {1'b0, dmag})
            begin
                part   = part - {1'b0, dmag};
                quo[i] = 1'b1;
            end
        end
        qneg = nneg ^ dneg;
        lim  = 64'd1 << (width - 1);
        if (quo[127:64] != '0 || quo[63:0] > lim || (quo[63:0] == lim && !qneg))
        begin
            res.status = STATUS_OVERFLOW;
            return res;
        end
        res.quotient  = (qneg ? (~quo[63:0] + 64'd1) : quo[63:0]) & mask;
        res.remainder = (nneg ? (~part[63:0] + 64'd1) : part[63:0]) & mask;
        return res;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        idiv_result_t exp_r;
        if (!rst_n)
        begin
            error_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (req_mon.valid && req_mon.ready)
                expected_results.push_back(compute_idiv(req_mon.op_size,
                    req_mon.dividend_high, req_mon.dividend_low,
                    req_mon.divisor_value));
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("ERROR: unexpected response beat q=%h r=%h s=%0d",
                                 rsp_mon.quotient, rsp_mon.remainder, rsp_mon.status);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (rsp_mon.quotient !== exp_r.quotient
                        || rsp_mon.remainder !== exp_r.remainder
                        || rsp_mon.status !== exp_r.status)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("ERROR: exp q=%h r=%h s=%0d got q=%h r=%h s=%0d",
                                     exp_r.quotient, exp_r.remainder, exp_r.status,
                                     rsp_mon.quotient, rsp_mon.remainder,
                                     rsp_mon.status);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random IDIV requests into the divide unit with random
// idling on both channels, a long response stall and a drain pause; the
// checker predicts and compares every response beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;
    import sidu_pkg::*;

    localparam int RANDOM_ITEMS = 1430;
    localparam int LATENCY      = 36;

    logic clk;
    logic rst_n;
    int   error_count;
    int   pending_count;
    bit   rsp_hold;
    bit   no_idle;

    sidu_req_if req ();
    sidu_rsp_if rsp ();

    signed_integer_divide_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    sidu_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_mon       (req.sink),
        .rsp_mon       (rsp.sink),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random value that is often narrow, signed-extended or an edge pattern.
    function automatic logic [63:0] pick_value(logic [1:0] size_code);
        int          width;
        logic [63:0] v;
        width = 8 << size_code;
        v = rand64();
        case ($urandom_range(0, 5))
            0: v = v >> $urandom_range(0, 63);
            1: v = ~(v >> $urandom_range(0, 63));
            2: v = 64'd1 << (width - 1);
            3: v = $urandom_range(0, 1) ? '1 : 64'd1;
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_beat(logic [1:0] size_code, logic [63:0] dhi,
                             logic [63:0] dlo, logic [63:0] dvr);
        while (!no_idle && $urandom_range(0, 99) < 34)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid         <= 1'b1;
        req.op_size       <= size_code;
        req.dividend_high <= dhi;
        req.dividend_low  <= dlo;
        req.divisor_value <= dvr;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        logic [1:0]  sz;
        logic [63:0] dhi;
        logic [63:0] dlo;
        logic [63:0] dvr;
        int          width;
        logic [63:0] q;
        sz    = 2'($urandom_range(0, 3));
        width = 8 << sz;
        dhi   = rand64();
        dlo   = rand64();
        dvr   = pick_value(sz);
        // Mostly keep the quotient in range by sign-extending the high half.
        if ($urandom_range(0, 99) < 70)
        begin
            q   = pick_value(sz);
            dlo = q;
            if (sz == SIZE_8)
                dlo[63:8] = {56{q[7]}} ^ (rand64() & 64'hFFFF_FFFF_FFFF_0000);
            else
                dhi = {64{q[width-1]}} ^ (rand64() << width);
        end
        send_beat(sz, dhi, dlo, dvr);
    endtask

    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready <= !rsp_hold && (no_idle || $urandom_range(0, 99) >= 34);
        end
    end

    initial
    begin
        int wait_cycles;
        req.valid         = 1'b0;
        req.op_size       = SIZE_8;
        req.dividend_high = '0;
        req.dividend_low  = '0;
        req.divisor_value = '0;
        rsp_hold          = 1'b0;
        no_idle           = 1'b0;
        rst_n             = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_beat(SIZE_8, '0, 64'h0000_0000_0000_0064, 64'h07);
        send_beat(SIZE_8, '0, 64'hFFFF_FFFF_FFFF_FF9C, 64'h07);
        send_beat(SIZE_8, '0, 64'h0064, 64'hFFFF_FF00);
        send_beat(SIZE_8, '1, 64'h8000, 64'hFF);
        send_beat(SIZE_8, '0, 64'h7F80, 64'hFF);
        send_beat(SIZE_8, '0, 64'h3F80, 64'h7F);
        send_beat(SIZE_8, '0, 64'hFF80, 64'hFF);
        send_beat(SIZE_16, 64'hFFFF, 64'h8000, 64'hFFFF);
        send_beat(SIZE_16, 64'hFFFF_0000, 64'hFFFF_0003, 64'h0002);
        send_beat(SIZE_16, 64'h4000, 64'h0000, 64'h8000);
        send_beat(SIZE_16, 64'hC000, 64'h0000, 64'h8000);
        send_beat(SIZE_32, 64'hFFFF_FFFF, 64'h8000_0000, 64'hFFFF_FFFF);
        send_beat(SIZE_32, 64'hFFFF_FFFF, 64'hFFFF_FFF9, 64'h0000_0002);
        send_beat(SIZE_32, '0, 64'h7FFF_FFFF, '1);
        send_beat(SIZE_32, 64'h1, '0, 64'hFFFF_FFFF_0000_0000);
        send_beat(SIZE_64, '1, 64'h8000_0000_0000_0000, '1);
        send_beat(SIZE_64, '0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
        send_beat(SIZE_64, '1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_beat(SIZE_64, 64'h3FFF_FFFF_FFFF_FFFF, '1, 64'h8000_0000_0000_0000);
        send_beat(SIZE_64, '1, '1, '1);
        send_beat(SIZE_64, '0, '0, 64'h1);
        send_beat(SIZE_64, '0, '1, '0);
        send_beat(SIZE_64, '1, '1, 64'h5555_5555_5555_5555);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i >= 300 && i < 500);
            if (i == 600)
                rsp_hold = 1'b1;
            if (i == 700)
            begin
                req.valid <= 1'b0;
                @(negedge clk);
                while (pending_count != 0)
                    @(negedge clk);
            end
            send_random();
        end
        req.valid <= 1'b0;

        wait_cycles = 0;
        while (pending_count != 0 && wait_cycles < 100000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(negedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Long response stall: the pipeline fills and req.ready drops.
    initial
    begin
        wait (rsp_hold);
        repeat (200) @(negedge clk);
        rsp_hold = 1'b0;
    end

endmodule

`default_nettype wire
